FILE: rtl/core/lslp_pkg.sv
// ----------------------------------------------------------------------------
// lslp_pkg
// shared types and constants of the linked list slot pool
// ----------------------------------------------------------------------------
package lslp_pkg;

  // default geometry
  localparam int SLOTS_DEF        = 128;
  localparam int PAYLOAD_BITS_DEF = 32;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_RESET_POOL = 2'd3
  } op_t;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_ADD_WR,
    ST_RM_LINK,
    ST_RM_COPY,
    ST_RM_FREE,
    ST_RM_HEAD,
    ST_TAIL_WALK,
    ST_TAIL_CUT,
    ST_CLR_WALK,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/core/lslp_req_if.sv
// ----------------------------------------------------------------------------
// lslp_req_if
// request channel of the slot pool: operation, list head, element, payload
// ----------------------------------------------------------------------------
interface lslp_req_if #(
  parameter int SLOTS        = lslp_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = lslp_pkg::PAYLOAD_BITS_DEF
);
  import lslp_pkg::*;

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int LINK_BITS = $clog2(SLOTS + 1);

  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic [LINK_BITS-1:0]    list_head;
  logic [SLOT_BITS-1:0]    element_slot;
  logic [PAYLOAD_BITS-1:0] payload_in;

  modport source (
    output valid, operation, list_head, element_slot, payload_in,
    input  ready
  );

  modport sink (
    input  valid, operation, list_head, element_slot, payload_in,
    output ready
  );

endinterface

FILE: rtl/core/lslp_rsp_if.sv
// ----------------------------------------------------------------------------
// lslp_rsp_if
// result channel of the slot pool: new head, added slot, status
// ----------------------------------------------------------------------------
interface lslp_rsp_if #(
  parameter int SLOTS = lslp_pkg::SLOTS_DEF
);
  localparam int LINK_BITS = $clog2(SLOTS + 1);

  logic                 valid;
  logic                 ready;
  logic [LINK_BITS-1:0] new_head;
  logic [LINK_BITS-1:0] added_slot;
  logic                 status;

  modport source (
    output valid, new_head, added_slot, status,
    input  ready
  );

  modport sink (
    input  valid, new_head, added_slot, status,
    output ready
  );

endinterface

FILE: rtl/core/linked_list_slot_pool.sv
// ----------------------------------------------------------------------------
// linked_list_slot_pool
// pool of slots with payload and next link, shared by a free list and
// caller-held singly linked lists
// ----------------------------------------------------------------------------
// The link and payload words sit in two single-port synchronous memories,
// and one sequencer takes one item at a time through read, modify and write
// steps on them; the link memory's one access per cycle sets the timing.
// An add pops the free head, fills it and pushes it on the list, or reports
// full when the pool is full; a remove of an element with a successor copies
// the successor in and frees it; a remove of the tail walks the list from its
// head; a clear walks to the tail and splices the list onto the free list; a
// pool reset rewrites the free chain, one slot a cycle. After rst the block
// runs the same sweep over the link memory before it takes its first item.
// A finished item waits in the output register while the next item is taken.
// The value SLOTS on a head or link means empty.
// ----------------------------------------------------------------------------
module linked_list_slot_pool #(
  parameter int SLOTS        = lslp_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = lslp_pkg::PAYLOAD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lslp_req_if.sink   req,
  lslp_rsp_if.source rsp
);
  import lslp_pkg::*;

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int LINK_BITS = $clog2(SLOTS + 1);
  localparam logic [LINK_BITS-1:0] EMPTY     = LINK_BITS'(SLOTS);
  localparam logic [LINK_BITS-1:0] LAST_STEP = LINK_BITS'(SLOTS - 1);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

  // memories
  logic [LINK_BITS-1:0]    link_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem  [SLOTS];

  logic                    rd_en;
  logic [SLOT_BITS-1:0]    rd_addr;
  logic [LINK_BITS-1:0]    link_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;
  logic                    link_we;
  logic [SLOT_BITS-1:0]    link_waddr;
  logic [LINK_BITS-1:0]    link_wdata;
  logic                    pay_we;
  logic [SLOT_BITS-1:0]    pay_waddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata;

  // sequencer registers
  state_t                  state, state_next;
  logic [SLOT_BITS-1:0]    idx, idx_next;
  logic                    fill_op, fill_op_next;
  logic [LINK_BITS-1:0]    free_head, free_head_next;
  logic [LINK_BITS-1:0]    head_q, head_next;
  logic [SLOT_BITS-1:0]    elem_q, elem_next;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_next;
  logic [SLOT_BITS-1:0]    cur, cur_next;
  logic [SLOT_BITS-1:0]    nxt, nxt_next;
  logic [LINK_BITS-1:0]    steps, steps_next;
  logic [LINK_BITS-1:0]    res_head, res_head_next;
  logic [LINK_BITS-1:0]    res_added, res_added_next;
  logic                    res_status, res_status_next;

  // output register
  logic                    out_valid, out_valid_next;
  logic [LINK_BITS-1:0]    out_head, out_head_next;
  logic [LINK_BITS-1:0]    out_added, out_added_next;
  logic                    out_status, out_status_next;

  logic [LINK_BITS-1:0]    in_head;
  logic                    in_elem_ok;

  // input head of SLOTS or more is an empty list
  assign in_head    = (req.list_head >= EMPTY) ? EMPTY : req.list_head;
  assign in_elem_ok = LINK_BITS'(req.element_slot) < EMPTY;

  // link memory, registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  // payload memory, read at the same address as the link memory
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (rd_en) begin
      pay_rd <= pay_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      idx       <= '0;
      fill_op   <= 1'b0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      fill_op   <= fill_op_next;
      free_head <= free_head_next;
      out_valid <= out_valid_next;
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    head_q     <= head_next;
    elem_q     <= elem_next;
    payload_q  <= payload_next;
    cur        <= cur_next;
    nxt        <= nxt_next;
    steps      <= steps_next;
    res_head   <= res_head_next;
    res_added  <= res_added_next;
    res_status <= res_status_next;
    out_head   <= out_head_next;
    out_added  <= out_added_next;
    out_status <= out_status_next;
  end

  // sequencer: one memory access per cycle, so a write never meets a read
  // of the same entry in one cycle
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    fill_op_next    = fill_op;
    free_head_next  = free_head;
    head_next       = head_q;
    elem_next       = elem_q;
    payload_next    = payload_q;
    cur_next        = cur;
    nxt_next        = nxt;
    steps_next      = steps;
    res_head_next   = res_head;
    res_added_next  = res_added;
    res_status_next = res_status;
    out_valid_next  = out_valid && !rsp.ready;
    out_head_next   = out_head;
    out_added_next  = out_added;
    out_status_next = out_status;
    req.ready       = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = cur;
    link_we         = 1'b0;
    link_waddr      = cur;
    link_wdata      = EMPTY;
    pay_we          = 1'b0;
    pay_waddr       = elem_q;
    pay_wdata       = payload_q;

    case (state)
      // rebuild the free chain, one slot a cycle
      ST_FILL: begin
        link_we    = 1'b1;
        link_waddr = idx;
        link_wdata = LINK_BITS'(idx) + LINK_BITS'(1);
        idx_next   = idx + SLOT_BITS'(1);
        if (idx == LAST_SLOT) begin
          idx_next       = '0;
          free_head_next = '0;
          state_next     = fill_op ? ST_RESULT : ST_IDLE;
        end
      end

      // take an item and issue its first read
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          head_next       = in_head;
          elem_next       = req.element_slot;
          payload_next    = req.payload_in;
          res_head_next   = in_head;
          res_added_next  = EMPTY;
          res_status_next = STATUS_OK;
          fill_op_next    = 1'b0;
          case (req.operation)
            OP_ADD: begin
              if (free_head == EMPTY) begin
                res_status_next = STATUS_FULL;
                state_next      = ST_RESULT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = free_head[SLOT_BITS-1:0];
                cur_next   = free_head[SLOT_BITS-1:0];
                state_next = ST_ADD_WR;
              end
            end
            OP_REMOVE: begin
              if (in_elem_ok) begin
                rd_en      = 1'b1;
                rd_addr    = req.element_slot;
                state_next = ST_RM_LINK;
              end else begin
                state_next = ST_RESULT;
              end
            end
            OP_CLEAR: begin
              if (in_head == EMPTY) begin
                state_next = ST_RESULT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = in_head[SLOT_BITS-1:0];
                cur_next   = in_head[SLOT_BITS-1:0];
                steps_next = '0;
                state_next = ST_CLR_WALK;
              end
            end
            OP_RESET_POOL: begin
              fill_op_next  = 1'b1;
              res_head_next = EMPTY;
              idx_next      = '0;
              state_next    = ST_FILL;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      // pop the free head, fill it and push it on the list
      ST_ADD_WR: begin
        free_head_next = link_rd;
        link_we        = 1'b1;
        link_waddr     = cur;
        link_wdata     = head_q;
        pay_we         = 1'b1;
        pay_waddr      = cur;
        pay_wdata      = payload_q;
        res_head_next  = LINK_BITS'(cur);
        res_added_next = LINK_BITS'(cur);
        state_next     = ST_RESULT;
      end

      // successor known: copy it in, else find the tail from the head
      ST_RM_LINK: begin
        if (link_rd != EMPTY) begin
          nxt_next   = link_rd[SLOT_BITS-1:0];
          rd_en      = 1'b1;
          rd_addr    = link_rd[SLOT_BITS-1:0];
          state_next = ST_RM_COPY;
        end else if (head_q != EMPTY) begin
          rd_en      = 1'b1;
          rd_addr    = head_q[SLOT_BITS-1:0];
          state_next = ST_RM_HEAD;
        end else begin
          state_next = ST_RESULT;
        end
      end

      // successor's link and payload into the element
      ST_RM_COPY: begin
        link_we    = 1'b1;
        link_waddr = elem_q;
        link_wdata = link_rd;
        pay_we     = 1'b1;
        pay_waddr  = elem_q;
        pay_wdata  = pay_rd;
        state_next = ST_RM_FREE;
      end

      // successor onto the free list
      ST_RM_FREE: begin
        link_we        = 1'b1;
        link_waddr     = nxt;
        link_wdata     = free_head;
        free_head_next = LINK_BITS'(nxt);
        state_next     = ST_RESULT;
      end

      // single-element list frees its head, else start the tail walk
      ST_RM_HEAD: begin
        if (link_rd == EMPTY) begin
          link_we        = 1'b1;
          link_waddr     = head_q[SLOT_BITS-1:0];
          link_wdata     = free_head;
          free_head_next = head_q;
          res_head_next  = EMPTY;
          state_next     = ST_RESULT;
        end else begin
          cur_next   = head_q[SLOT_BITS-1:0];
          nxt_next   = link_rd[SLOT_BITS-1:0];
          steps_next = '0;
          rd_en      = 1'b1;
          rd_addr    = link_rd[SLOT_BITS-1:0];
          state_next = ST_TAIL_WALK;
        end
      end

      // link_rd is the link of nxt; a tail at nxt is freed
      ST_TAIL_WALK: begin
        if (link_rd == EMPTY) begin
          link_we        = 1'b1;
          link_waddr     = nxt;
          link_wdata     = free_head;
          free_head_next = LINK_BITS'(nxt);
          state_next     = ST_TAIL_CUT;
        end else if (steps == LAST_STEP) begin
          state_next = ST_RESULT;
        end else begin
          cur_next   = nxt;
          nxt_next   = link_rd[SLOT_BITS-1:0];
          steps_next = steps + LINK_BITS'(1);
          rd_en      = 1'b1;
          rd_addr    = link_rd[SLOT_BITS-1:0];
        end
      end

      // old predecessor becomes the tail
      ST_TAIL_CUT: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = EMPTY;
        state_next = ST_RESULT;
      end

      // walk to the tail, then splice the list onto the free list
      ST_CLR_WALK: begin
        if (link_rd == EMPTY) begin
          link_we        = 1'b1;
          link_waddr     = cur;
          link_wdata     = free_head;
          free_head_next = head_q;
          res_head_next  = EMPTY;
          state_next     = ST_RESULT;
        end else if (steps == EMPTY) begin
          state_next = ST_RESULT;
        end else begin
          cur_next   = link_rd[SLOT_BITS-1:0];
          steps_next = steps + LINK_BITS'(1);
          rd_en      = 1'b1;
          rd_addr    = link_rd[SLOT_BITS-1:0];
        end
      end

      // hand the item to the output register once it is free
      ST_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_head_next   = res_head;
          out_added_next  = res_added;
          out_status_next = res_status;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.new_head   = out_head;
  assign rsp.added_slot = out_added;
  assign rsp.status     = out_status;

`ifndef ASSERT_OFF
  // free list head is a slot or the empty mark
  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= EMPTY)
    else $error("free head out of range");

  // an item appears on the output only out of the result step
  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_RESULT))
    else $error("output item without result step");

  // a taken slot always comes with ok status
  a_added_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.added_slot != EMPTY) |-> rsp.status == STATUS_OK)
    else $error("added slot reported with full status");

  // no memory write while waiting for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !link_we && !pay_we)
    else $error("memory write in idle");
`endif

endmodule

FILE: tb/sv/lslp_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lslp_tb_pkg
// shadow copy of the slot pool: tracks links, free head and written payload
// slots, works out the reply of every accepted item and checks the replies
// ----------------------------------------------------------------------------
package lslp_tb_pkg;
  import lslp_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
  localparam int LINK_BITS    = $clog2(SLOTS + 1);
  localparam int SLOT_BITS    = $clog2(SLOTS);
  localparam int MAX_REPORTS  = 100;

  typedef logic [LINK_BITS-1:0]    link_t;
  typedef logic [SLOT_BITS-1:0]    slot_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  typedef struct packed {
    link_t new_head;
    link_t added_slot;
    logic  status;
  } pool_reply_t;

  class slot_pool_shadow;
    link_t       link_mem [SLOTS];
    bit          payload_set [SLOTS];
    link_t       free_head;
    pool_reply_t replies_due [$];
    pool_reply_t last_reply;
    int          errors;

    function new();
      errors = 0;
      foreach (payload_set[i]) payload_set[i] = 1'b0;
      rebuild_chain();
    endfunction

    // free chain 0 -> 1 -> ... -> last -> empty
    function void rebuild_chain();
      foreach (link_mem[i]) link_mem[i] = link_t'(i + 1);
      free_head = '0;
    endfunction

    function void free_slot(int s);
      link_mem[s] = free_head;
      free_head   = link_t'(s);
    endfunction

    // a remove that would copy a payload word never written
    function bit reads_blank(slot_t e);
      return link_mem[e] != SLOTS && !payload_set[link_mem[e]];
    endfunction

    // follow a list for some hops, stopping at its tail
    function slot_t walk_from(link_t head, int hops);
      link_t cur;
      int    i;
      cur = head;
      for (i = 0; i < hops && link_mem[cur] != SLOTS; i++) cur = link_mem[cur];
      return slot_t'(cur);
    endfunction

    // update the pool for one accepted item and queue its reply
    function void apply_request(op_t op, link_t head_in, slot_t elem);
      int          head, s, nx, cur, n, steps;
      pool_reply_t r;
      head = (head_in < SLOTS) ? int'(head_in) : SLOTS;
      r.new_head   = link_t'(head);
      r.added_slot = link_t'(SLOTS);
      r.status     = STATUS_OK;
      case (op)
        OP_ADD: begin
          if (free_head >= SLOTS) begin
            r.status = STATUS_FULL;
          end else begin
            s = free_head;
            free_head      = link_mem[s];
            payload_set[s] = 1'b1;
            link_mem[s]    = link_t'(head);
            r.new_head     = link_t'(s);
            r.added_slot   = link_t'(s);
          end
        end
        OP_REMOVE: begin
          nx = link_mem[elem];
          if (nx != SLOTS) begin
            // pull the successor into the element and free the successor
            payload_set[elem] = payload_set[nx];
            link_mem[elem]    = link_mem[nx];
            free_slot(nx);
          end else if (head != SLOTS) begin
            if (link_mem[head] == SLOTS) begin
              free_slot(head);
              r.new_head = link_t'(SLOTS);
            end else begin
              // find the slot before the tail, give up on a cycle
              cur = head;
              for (steps = 0; steps < SLOTS; steps++) begin
                n = link_mem[cur];
                if (link_mem[n] == SLOTS) begin
                  free_slot(n);
                  link_mem[cur] = link_t'(SLOTS);
                  break;
                end
                cur = n;
              end
            end
          end
        end
        OP_CLEAR: begin
          if (head != SLOTS) begin
            cur   = head;
            steps = 0;
            while (link_mem[cur] != SLOTS && steps < SLOTS) begin
              cur = link_mem[cur];
              steps++;
            end
            // splice the whole list in front of the free list
            if (link_mem[cur] == SLOTS) begin
              link_mem[cur] = free_head;
              free_head     = link_t'(head);
              r.new_head    = link_t'(SLOTS);
            end
          end
        end
        default: begin
          rebuild_chain();
          r.new_head = link_t'(SLOTS);
        end
      endcase
      last_reply = r;
      replies_due.push_back(r);
    endfunction

    function void flag_field(string field, link_t want, link_t got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // compare one reply with the oldest one due
    function void check_reply(link_t new_head, link_t added_slot, logic status);
      pool_reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: reply with none expected, actual new_head %0d added_slot %0d status %0d",
                   $time, new_head, added_slot, status);
        return;
      end
      want = replies_due.pop_front();
      if (new_head !== want.new_head) flag_field("new_head", want.new_head, new_head);
      if (added_slot !== want.added_slot) flag_field("added_slot", want.added_slot, added_slot);
      if (status !== want.status) flag_field("status", link_t'(want.status), link_t'(status));
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/linked_list_slot_pool_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linked_list_slot_pool_tb
// drives add, remove, clear and pool reset items into the slot pool, keeps a
// shadow copy of the pool to work out each reply, and checks every reply in
// order; directed corner cases first, then random list traffic with a pool
// fill, a drain by removes, random idling on both sides and one long
// hold-off on the reply side
// ----------------------------------------------------------------------------
module linked_list_slot_pool_tb;
  import lslp_pkg::*;
  import lslp_tb_pkg::*;

  localparam int RANDOM_ITEMS    = 400;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_AT     = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = SLOTS + 20;

  logic  clk;
  logic  rst;
  bit    calm;
  bit    gaps_on;
  link_t lists [4];

  slot_pool_shadow sb = new();

  lslp_req_if req ();
  lslp_rsp_if rsp ();

  linked_list_slot_pool dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one item, wait for it to be taken, then maybe idle a little
  task automatic send_item(input op_t op, input link_t head, input slot_t elem,
                           input payload_t payload);
    if (op == OP_REMOVE && sb.reads_blank(elem)) op = OP_ADD;
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.list_head    <= head;
    req.element_slot <= elem;
    req.payload_in   <= payload;
    do @(posedge clk); while (!req.ready);
    sb.apply_request(op, head, elem);
    if (op == OP_RESET_POOL) foreach (lists[i]) lists[i] = link_t'(SLOTS);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // item on one of the caller lists, whose head follows the reply
  task automatic list_op(input op_t op, input int idx, input link_t head,
                         input slot_t elem, input payload_t payload);
    send_item(op, head, elem, payload);
    lists[idx] = sb.last_reply.new_head;
  endtask

  // fresh pool, then adds until it reports full twice
  task automatic fill_pool();
    int fulls, i, idx;
    fulls = 0;
    list_op(OP_RESET_POOL, 0, lists[0], '0, $urandom());
    for (i = 0; i < SLOTS + 8 && fulls < 2; i++) begin
      idx = $urandom_range(0, 3);
      list_op(OP_ADD, idx, lists[idx], slot_t'($urandom_range(0, SLOTS - 1)), $urandom());
      if (sb.last_reply.status == STATUS_FULL) fulls++;
    end
  endtask

  // mostly well-formed list traffic, some items on random heads
  task automatic random_item(input bit drain);
    int    pick, idx, add_w, rem_w;
    slot_t elem;
    add_w = drain ? 15 : 45;
    rem_w = drain ? 70 : 35;
    pick  = $urandom_range(0, 99);
    idx   = $urandom_range(0, 3);
    elem  = slot_t'($urandom_range(0, SLOTS - 1));
    if (pick < 8) begin
      send_item(op_t'($urandom_range(0, 2)), link_t'($urandom_range(0, 255)), elem, $urandom());
    end else if (pick < 8 + add_w) begin
      list_op(OP_ADD, idx, lists[idx], elem, $urandom());
    end else if (pick < 8 + add_w + rem_w) begin
      if (lists[idx] < SLOTS)
        elem = sb.walk_from(lists[idx], $urandom_range(0, 1) ? SLOTS : $urandom_range(0, 4));
      list_op(OP_REMOVE, idx, lists[idx], elem, $urandom());
    end else if (pick < 98) begin
      list_op(OP_CLEAR, idx, lists[idx], elem, $urandom());
    end else begin
      list_op(OP_RESET_POOL, idx, lists[idx], elem, $urandom());
    end
  endtask

  // stimulus and end of run
  initial begin
    int n;
    calm    = 1'b0;
    gaps_on = 1'b1;
    foreach (lists[i]) lists[i] = link_t'(SLOTS);
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.operation    <= OP_ADD;
    req.list_head    <= '0;
    req.element_slot <= '0;
    req.payload_in   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // build small lists, heads out of range taken as empty
    list_op(OP_ADD, 0, lists[0], '0, '0);
    list_op(OP_ADD, 0, lists[0], '1, '1);
    list_op(OP_ADD, 1, 8'hFF, '0, $urandom());
    list_op(OP_ADD, 2, link_t'(SLOTS + 1), '0, $urandom());
    // head with a successor, then the sole element, then an empty list
    list_op(OP_REMOVE, 0, lists[0], slot_t'(lists[0]), $urandom());
    list_op(OP_REMOVE, 0, lists[0], slot_t'(lists[0]), $urandom());
    list_op(OP_REMOVE, 0, link_t'(SLOTS), slot_t'(SLOTS - 1), $urandom());
    // tail remove by walking a longer list
    repeat (3) list_op(OP_ADD, 0, lists[0], '0, $urandom());
    list_op(OP_REMOVE, 0, lists[0], sb.walk_from(lists[0], SLOTS), $urandom());
    list_op(OP_CLEAR, 0, lists[0], '0, $urandom());
    list_op(OP_CLEAR, 1, lists[1], '0, $urandom());
    list_op(OP_CLEAR, 0, 8'd200, '0, $urandom());
    // a slot linked to itself: walks never reach a tail
    list_op(OP_ADD, 3, sb.free_head, '0, $urandom());
    list_op(OP_CLEAR, 3, lists[3], '0, $urandom());
    list_op(OP_REMOVE, 3, lists[3], slot_t'(lists[2]), $urandom());
    list_op(OP_REMOVE, 3, lists[3], slot_t'(lists[3]), $urandom());
    send_item(OP_REMOVE, 8'hFF, '0, $urandom());
    list_op(OP_RESET_POOL, 0, lists[0], '0, $urandom());
    list_op(OP_ADD, 0, lists[0], '1, 32'h5555_AAAA);

    // random traffic: balanced, pool fill, drain, balanced with no idling
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = ((n / 50) % 3) != 2;
      calm    = n >= RANDOM_ITEMS - 70;
      if (n == 120) fill_pool();
      random_item(n >= 120 && n < 220);
    end
    req.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("linked_list_slot_pool_tb: done, clean");
    end else begin
      $display("linked_list_slot_pool_tb: done, errors");
    end
    $finish;
  end

  // reply side: check, random stalls, one long hold-off
  initial begin
    int stall_left, hold_left, replies;
    stall_left = 0;
    hold_left  = 0;
    replies    = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        sb.check_reply(rsp.new_head, rsp.added_slot, rsp.status);
        replies++;
        if (replies == HOLD_OFF_AT) hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("linked_list_slot_pool_tb: done, errors");
    $finish;
  end

endmodule

FILE: linked_list_slot_pool.f
rtl/core/lslp_pkg.sv
rtl/core/lslp_req_if.sv
rtl/core/lslp_rsp_if.sv
rtl/core/linked_list_slot_pool.sv
tb/sv/lslp_tb_pkg.sv
tb/sv/linked_list_slot_pool_tb.sv
